### sv/nrpc_pkg.sv
// shared types, constants and helper functions for the nearest palette color match
package nrpc_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int PALETTE_MAX         = 256;
  localparam int CH_W                = 8;
  localparam int IDX_W               = 8;
  localparam int CODE_W              = 16;
  localparam int SQ_W                = 2 * CH_W;
  localparam int ERR_W               = 18;

  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_t;

  typedef enum logic {
    FMT_565 = 1'b0,
    FMT_555 = 1'b1
  } fmt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    kind_t             kind;
    logic [IDX_W-1:0]  entry_index;
    logic [CH_W-1:0]   entry_red;
    logic [CH_W-1:0]   entry_green;
    logic [CH_W-1:0]   entry_blue;
    logic [CODE_W-1:0] pixel_code;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] nearest_index;
    logic [ERR_W-1:0] nearest_error;
  } out_t;

  function automatic rgb_t expand_code(input logic [CODE_W-1:0] code, input fmt_t fmt);
    rgb_t c;
    c.blue = {code[4:0], 3'b000};
    if (fmt == FMT_565) begin
      c.red   = {code[15:11], 3'b000};
      c.green = {code[10:5], 2'b00};
    end else begin
      c.red   = {code[14:10], 3'b000};
      c.green = {code[9:5], 3'b000};
    end
    return c;
  endfunction

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    logic [CH_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

### sv/nrpc_palette_mem.sv
// palette memory with per-entry valid bits, one write port and one registered read port
module nrpc_palette_mem #(
  parameter int PALETTE_ENTRIES = nrpc_pkg::PALETTE_ENTRIES_DEF,
  localparam int AW = $clog2(PALETTE_ENTRIES)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  nrpc_pkg::rgb_t wr_data,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr,
  output nrpc_pkg::rgb_t rd_data
);

  nrpc_pkg::rgb_t             mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] valid_r;
  nrpc_pkg::rgb_t             rd_data_r;
  logic                       rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  // entries never written read as black
  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

### sv/nrpc_search.sv
// scan sequencer, distance pipeline and running minimum for one lookup
module nrpc_search #(
  parameter int PALETTE_ENTRIES = nrpc_pkg::PALETTE_ENTRIES_DEF,
  localparam int AW = $clog2(PALETTE_ENTRIES)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [nrpc_pkg::CODE_W-1:0]   code,
  input  nrpc_pkg::fmt_t                fmt,
  output logic                          busy,
  output logic                          rd_en,
  output logic [AW-1:0]                 rd_addr,
  input  nrpc_pkg::rgb_t                rd_data,
  output logic                          out_strobe,
  output nrpc_pkg::out_t                out_data
);

  nrpc_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    cnt_r;
  logic             last_issue;
  nrpc_pkg::rgb_t   tgt_r;

  logic             s1_v_r, s1_last_r, s1_first_r;
  logic [AW-1:0]    s1_idx_r;
  logic             s2_v_r, s2_last_r, s2_first_r;
  logic [AW-1:0]    s2_idx_r;
  logic [nrpc_pkg::SQ_W-1:0] s2_sq_r [3];

  logic [nrpc_pkg::ERR_W-1:0] err;
  logic                       take;
  logic [AW-1:0]              best_idx_r;
  logic [nrpc_pkg::ERR_W-1:0] best_err_r;
  logic                       out_strobe_r;
  nrpc_pkg::out_t             out_data_r;

  assign last_issue = (cnt_r == AW'(PALETTE_ENTRIES - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nrpc_pkg::ST_IDLE:  if (go) state_nxt = nrpc_pkg::ST_SCAN;
      nrpc_pkg::ST_SCAN:  if (last_issue) state_nxt = nrpc_pkg::ST_DRAIN;
      nrpc_pkg::ST_DRAIN: if (s2_v_r && s2_last_r) state_nxt = nrpc_pkg::ST_IDLE;
      default:            state_nxt = nrpc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = 1'b1;
    rd_en = 1'b0;
    unique case (state_r)
      nrpc_pkg::ST_IDLE: busy  = 1'b0;
      nrpc_pkg::ST_SCAN: rd_en = 1'b1;
      default: begin
        busy  = 1'b1;
        rd_en = 1'b0;
      end
    endcase
  end

  assign rd_addr = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= nrpc_pkg::ST_IDLE;
      cnt_r        <= '0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      s1_v_r       <= rd_en;
      s2_v_r       <= s1_v_r;
      out_strobe_r <= s2_v_r && s2_last_r;
      if (state_r == nrpc_pkg::ST_IDLE) begin
        cnt_r <= '0;
      end else if (rd_en) begin
        cnt_r <= cnt_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && !busy) begin
      tgt_r <= nrpc_pkg::expand_code(code, fmt);
    end
    s1_last_r  <= last_issue;
    s1_first_r <= (cnt_r == '0);
    s1_idx_r   <= cnt_r;
    s2_last_r  <= s1_last_r;
    s2_first_r <= s1_first_r;
    s2_idx_r   <= s1_idx_r;
    s2_sq_r[0] <= nrpc_pkg::sq_diff(rd_data.red, tgt_r.red);
    s2_sq_r[1] <= nrpc_pkg::sq_diff(rd_data.green, tgt_r.green);
    s2_sq_r[2] <= nrpc_pkg::sq_diff(rd_data.blue, tgt_r.blue);
  end

  assign err  = nrpc_pkg::ERR_W'(s2_sq_r[0]) + nrpc_pkg::ERR_W'(s2_sq_r[1])
              + nrpc_pkg::ERR_W'(s2_sq_r[2]);
  // strict less keeps the lowest index on a tie
  assign take = s2_first_r || (err < best_err_r);

  always_ff @(posedge clk) begin
    if (s2_v_r && take) begin
      best_idx_r <= s2_idx_r;
      best_err_r <= err;
    end
    if (s2_v_r && s2_last_r) begin
      out_data_r.nearest_index <= take ? nrpc_pkg::IDX_W'(s2_idx_r)
                                       : nrpc_pkg::IDX_W'(best_idx_r);
      out_data_r.nearest_error <= take ? err : best_err_r;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

### sv/nearest_palette_color_match.sv
// Nearest palette color match: a load transaction writes one palette entry in the cycle it is
// accepted and leaves busy low; a lookup transaction raises busy, reads the palette memory one
// entry per cycle and shows the lowest index of least squared RGB distance on out_strobe after
// the scan and its distance pipeline drain, in the same cycle that busy drops; the scan length
// is set by the single read port of the palette memory. The result is shown for one cycle and
// cannot be held off by the receiver. Reset clears the palette through per-entry valid bits, so
// no clearing pass is needed.
module nearest_palette_color_match #(
  parameter int PALETTE_ENTRIES = nrpc_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  nrpc_pkg::in_t  in_data,
  output logic           out_strobe,
  output nrpc_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic           cfg_wdata
);

  localparam int AW = $clog2(PALETTE_ENTRIES);

  nrpc_pkg::fmt_t fmt_r;
  logic           accept;
  logic           load_en;
  logic           lookup_go;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  nrpc_pkg::rgb_t rd_data;
  nrpc_pkg::rgb_t wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= nrpc_pkg::FMT_565;
    end else if (cfg_we) begin
      fmt_r <= nrpc_pkg::fmt_t'(cfg_wdata);
    end
  end

  assign accept    = start && !busy;
  assign load_en   = accept && (in_data.kind == nrpc_pkg::KIND_LOAD)
                  && ({1'b0, in_data.entry_index} < (nrpc_pkg::IDX_W + 1)'(PALETTE_ENTRIES));
  assign lookup_go = accept && (in_data.kind == nrpc_pkg::KIND_LOOKUP);

  assign wr_data.red   = in_data.entry_red;
  assign wr_data.green = in_data.entry_green;
  assign wr_data.blue  = in_data.entry_blue;

  nrpc_palette_mem #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (load_en),
    .wr_addr (in_data.entry_index[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  nrpc_search #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_search (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (lookup_go),
    .code       (in_data.pixel_code),
    .fmt        (fmt_r),
    .busy       (busy),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

### sv/nrpc_checker.sv
// port-level checks for the nearest palette color match, bound to the top level
module nrpc_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input nrpc_pkg::in_t  in_data,
  input logic           out_strobe,
  input nrpc_pkg::out_t out_data
);

  localparam logic [nrpc_pkg::ERR_W-1:0] MaxErr = nrpc_pkg::ERR_W'(195075);

  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.kind == nrpc_pkg::KIND_LOOKUP) |=> busy)
    else $error("lookup transaction did not raise busy");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.kind == nrpc_pkg::KIND_LOAD) |=> !busy)
    else $error("load transaction raised busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without a lookup in progress");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.nearest_error <= MaxErr))
    else $error("distance out of range");

endmodule

bind nearest_palette_color_match nrpc_checker u_nrpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_data    (in_data),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
